/* rtl/lpt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpt_pkg
// Request kinds, status codes, request/result structs and the
// controller-to-datapath command and status bundles.
// ----------------------------------------------------------------------------
package lpt_pkg;

	localparam int unsigned IDX_W   = 16;
	localparam int unsigned CNT_W   = 17;
	localparam int unsigned OFF_W   = 27;
	localparam int unsigned LEN11_W = 11;

	// request kinds
	localparam logic [2:0] REQ_PLACE   = 3'd0;
	localparam logic [2:0] REQ_READ    = 3'd1;
	localparam logic [2:0] REQ_QUERY   = 3'd2;
	localparam logic [2:0] REQ_SCAN    = 3'd3;
	localparam logic [2:0] REQ_RESTORE = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_BAD    = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	// config register addresses
	localparam logic [0:0] REG_LEAF_COUNT = 1'b0;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] leaf_index;
		logic [15:0] length;
		logic        proof_ok;
		logic [7:0]  restore_bits;
	} lpt_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        present_bit;
		logic [15:0] found_index;
		logic        write_enable;
		logic [26:0] slot_offset;
		logic [10:0] pad_length;
		logic [10:0] read_length;
		logic [16:0] have_count;
		logic        complete;
		logic        sync_request;
	} lpt_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_step;   // clear word at pointer, advance pointer
		logic latch;      // capture request, set pointer to its word
		logic rd;         // issue memory read at pointer
		logic exec;       // decide on read word, write back, emit result
		logic cnt_init;   // start recount from word zero
		logic cnt_step;   // add popcount of read word, advance
		logic scan_step;  // examine read word for a missing leaf
	} lpt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_done;
		logic cnt_done;
		logic scan_done;
		logic is_scan;
	} lpt_sts_t;

endpackage
`default_nettype wire

/* rtl/lpt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpt_ctrl
// Sequencer: clearing pass after reset, request read-modify-write, word scan
// and recount after a leaf_count write.
// ----------------------------------------------------------------------------
module lpt_ctrl
	import lpt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     cfg_wr,
	input  wire lpt_sts_t sts,
	output lpt_cmd_t      cmd,
	output logic          busy
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_RD    = 7'b0000100,
		S_EXEC  = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_CRD   = 7'b0100000,
		S_CNT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cfg_wr) begin
					cmd.cnt_init = 1'b1;
					state_d      = S_CRD;
				end else if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = sts.is_scan ? S_SCAN : S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				state_d       = sts.scan_done ? S_IDLE : S_RD;
			end
			S_CRD: begin
				cmd.rd  = 1'b1;
				state_d = S_CNT;
			end
			S_CNT: begin
				cmd.cnt_step = 1'b1;
				state_d      = sts.cnt_done ? S_IDLE : S_CRD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_d;
	end

	// recount also blocks requests
	assign busy = (state_q != S_IDLE) || cfg_wr;

endmodule
`default_nettype wire

/* rtl/lpt_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpt_dp
// Datapath: bitmap memory, present count, request decision, scan and recount
// word walkers, result register.
// ----------------------------------------------------------------------------
module lpt_dp
	import lpt_pkg::*;
#(
	parameter int unsigned MAX_LEAVES    = 65536,
	parameter int unsigned SLOT_STRIDE   = 1056,
	parameter int unsigned MAP_WORD_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lpt_cmd_t         cmd,
	input  wire lpt_req_t         req,
	input  wire logic [CNT_W-1:0] leaf_count,
	output lpt_sts_t              sts,
	output lpt_rsp_t              rsp,
	output logic                  rsp_valid
);

	localparam int unsigned DEPTH = (MAX_LEAVES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned BW    = (MAP_WORD_BITS > 1) ? $clog2(MAP_WORD_BITS) : 1;
	localparam int unsigned LW    = $clog2(MAX_LEAVES + 1) + 1;
	localparam int unsigned PW    = $clog2(MAP_WORD_BITS + 1);
	localparam logic [LW-1:0] MAXL = LW'(MAX_LEAVES);
	localparam logic [16:0]   STR  = 17'(SLOT_STRIDE);

	logic [MAP_WORD_BITS-1:0] mem [DEPTH];
	logic [MAP_WORD_BITS-1:0] rdata_q;
	logic [AW:0]              ptr_q;
	lpt_req_t                 req_q;
	logic [CNT_W-1:0]         total_q;
	logic [CNT_W-1:0]         n_q;
	logic                     scan_first_q;
	logic                     scan_was_q;

	// effective leaf count
	logic [CNT_W-1:0] n_eff;
	always_comb begin
		if (LW'(leaf_count) > MAXL) n_eff = '0;
		else                        n_eff = leaf_count;
	end

	// memory write port signals
	logic                     we;
	logic [AW-1:0]            waddr;
	logic [MAP_WORD_BITS-1:0] wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (cmd.rd) rdata_q <= mem[ptr_q[AW-1:0]];
	end

	// request decode
	logic [LW-1:0]      idx_l;
	logic               in_rng;
	logic [BW-1:0]      bsel;
	logic               was;
	logic               len_bad;
	logic [OFF_W-1:0]   mul_off;
	always_comb begin
		idx_l   = LW'(req_q.leaf_index);
		in_rng  = idx_l < LW'(n_q);
		bsel    = BW'(req_q.leaf_index);
		was     = in_rng && rdata_q[bsel];
		len_bad = (req_q.length == 16'd0) || (17'(req_q.length) > STR);
		mul_off = OFF_W'(req_q.leaf_index) * OFF_W'(STR);
	end

	// restore byte: base and per-bit masks within the word
	logic [LW-1:0]            rbase;
	logic [MAP_WORD_BITS-1:0] rs_word;
	logic [CNT_W-1:0]         rs_old, rs_new;
	logic                     rs_range;
	always_comb begin
		rbase    = idx_l & ~LW'(7);
		rs_range = rbase >= MAXL;
		rs_word  = rdata_q;
		rs_old   = '0;
		rs_new   = '0;
		for (int i = 0; i < 8; i++) begin
			if ((rbase + LW'(i)) < MAXL) begin
				if ((rbase + LW'(i)) < LW'(n_q)) begin
					rs_old = rs_old + CNT_W'(rdata_q[BW'(rbase + LW'(i))]);
					rs_new = rs_new + CNT_W'(req_q.restore_bits[i]);
				end
				rs_word[BW'(rbase + LW'(i))] = req_q.restore_bits[i];
			end
		end
	end

	// scan / recount word view: leaves of word at ptr
	logic [LW-1:0]            wbase;
	logic [MAP_WORD_BITS-1:0] miss;
	logic                     miss_any;
	logic [BW-1:0]            miss_pos;
	logic [PW-1:0]            pop;
	always_comb begin
		wbase    = LW'(ptr_q) << BW;
		miss     = '0;
		pop      = '0;
		miss_any = 1'b0;
		miss_pos = '0;
		for (int i = 0; i < MAP_WORD_BITS; i++) begin
			if ((wbase + LW'(i)) < LW'(n_q)) begin
				pop = pop + PW'(rdata_q[i]);
				if ((wbase + LW'(i)) >= idx_l && !rdata_q[i]) miss[i] = 1'b1;
			end
		end
		for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
			if (miss[i]) begin
				miss_any = 1'b1;
				miss_pos = BW'(i);
			end
		end
	end

	logic [LW-1:0] nxt_base;
	assign nxt_base = wbase + LW'(MAP_WORD_BITS);

	assign sts.clr_done  = ptr_q == (AW+1)'(DEPTH - 1);
	assign sts.cnt_done  = nxt_base >= LW'(n_q);
	assign sts.scan_done = miss_any || (nxt_base >= LW'(n_q));
	assign sts.is_scan   = req_q.req_type == REQ_SCAN;

	// write port
	logic [MAP_WORD_BITS-1:0] place_word;
	always_comb begin
		place_word       = rdata_q;
		place_word[bsel] = 1'b1;
		we    = 1'b0;
		waddr = ptr_q[AW-1:0];
		wdata = '0;
		if (cmd.clr_step) begin
			we = 1'b1;
		end else if (cmd.exec) begin
			if (req_q.req_type == REQ_PLACE && in_rng && !len_bad && !was && req_q.proof_ok) begin
				we    = 1'b1;
				wdata = place_word;
			end else if (req_q.req_type == REQ_RESTORE && !rs_range) begin
				we    = 1'b1;
				wdata = rs_word;
			end
		end
	end

	// pointer, request, count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			total_q <= '0;
			n_q     <= '0;
		end else begin
			if (cmd.clr_step) ptr_q <= ptr_q + (AW+1)'(1);
			if (cmd.latch) begin
				ptr_q <= (AW+1)'(LW'(req.leaf_index) >> BW);
				n_q   <= n_eff;
			end
			if (cmd.cnt_init) begin
				ptr_q   <= '0;
				total_q <= '0;
				n_q     <= n_eff;
			end
			if (cmd.cnt_step) begin
				total_q <= total_q + CNT_W'(pop);
				ptr_q   <= ptr_q + (AW+1)'(1);
			end
			if (cmd.scan_step && !miss_any) ptr_q <= ptr_q + (AW+1)'(1);
			if (cmd.exec) begin
				if (req_q.req_type == REQ_PLACE && in_rng && !len_bad && !was && req_q.proof_ok)
					total_q <= total_q + CNT_W'(1);
				else if (req_q.req_type == REQ_RESTORE && !rs_range)
					total_q <= total_q - rs_old + rs_new;
			end
		end
	end

	// request capture; a scan keeps the start leaf's bit from its first word
	always_ff @(posedge clk) begin
		if (cmd.latch) req_q <= req;
		if (cmd.latch)          scan_first_q <= 1'b1;
		else if (cmd.scan_step) scan_first_q <= 1'b0;
		if (cmd.scan_step && scan_first_q) scan_was_q <= was;
	end

	// result
	lpt_rsp_t         r;
	logic [CNT_W-1:0] tot_new;
	always_comb begin
		r       = '0;
		tot_new = total_q;
		r.present_bit = (cmd.scan_step && !scan_first_q) ? scan_was_q : was;
		if (cmd.scan_step) begin
			r.status = ST_ABSENT;
			if (miss_any && in_rng) begin
				r.status      = ST_OK;
				r.found_index = 16'(wbase + LW'(miss_pos));
			end
		end else begin
			case (req_q.req_type)
				REQ_PLACE: begin
					if (!in_rng)      r.status = ST_RANGE;
					else if (len_bad) r.status = ST_BAD;
					else if (was)     r.status = ST_OK;
					else if (!req_q.proof_ok) r.status = ST_BAD;
					else begin
						r.write_enable = 1'b1;
						r.slot_offset  = mul_off;
						r.pad_length   = LEN11_W'(STR - 17'(req_q.length));
						tot_new        = total_q + CNT_W'(1);
						r.sync_request = tot_new == n_q;
					end
				end
				REQ_READ: begin
					if (!in_rng)   r.status = ST_RANGE;
					else if (!was) r.status = ST_ABSENT;
					else begin
						r.slot_offset = mul_off;
						r.read_length = (17'(req_q.length) < STR) ?
							LEN11_W'(req_q.length) : LEN11_W'(STR);
					end
				end
				REQ_QUERY: r.status = in_rng ? ST_OK : ST_RANGE;
				REQ_RESTORE: begin
					if (rs_range) r.status = ST_RANGE;
					else tot_new = total_q - rs_old + rs_new;
				end
				default: r.status = ST_OK;
			endcase
		end
		r.have_count = tot_new;
		r.complete   = (n_q != '0) && (tot_new == n_q);
	end

	logic emit;
	assign emit = cmd.exec || (cmd.scan_step && sts.scan_done);

	always_ff @(posedge clk) begin
		if (emit) rsp <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid <= 1'b0;
		else         rsp_valid <= emit;
	end

endmodule
`default_nettype wire

/* rtl/leaf_presence_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// leaf_presence_tracker
// Presence bitmap and leaf count for an out-of-order fixed-stride transfer.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests: drive req and pulse start while busy is low; the request is
//    taken at that edge. One result per request appears on rsp, marked by
//    done, high for exactly one cycle; the receiver cannot stall it.
//  - Place, read, query and restore: memory read, decide and write back,
//    result register, then done; busy is high until the result is
//    registered, so a new request is taken only after the last is through.
//  - Next-missing scan walks the bitmap one word at a time through the
//    memory read port, reading then examining each word; done follows the
//    last word visited.
//  - Writing leaf_count recounts present leaves word by word, reading then
//    adding each (at least one word); busy is high meanwhile.
//  - After reset the bitmap memory is cleared one word a cycle
//    (MAX_LEAVES/MAP_WORD_BITS words, 2048 by default); busy stays high.
//  - APB: one register, leaf_count at address 0; pready is always high.
// ----------------------------------------------------------------------------
module leaf_presence_tracker
	import lpt_pkg::*;
#(
	parameter int unsigned MAX_LEAVES    = 65536,
	parameter int unsigned SLOT_STRIDE   = 1056,
	parameter int unsigned MAP_WORD_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire lpt_req_t    req,
	output logic             busy,
	output logic             done,
	output lpt_rsp_t         rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [0:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [CNT_W-1:0] leaf_count_q;
	logic [CNT_W-1:0] leaf_count_d;
	logic             cfg_wr;
	lpt_cmd_t         cmd;
	lpt_sts_t         sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_LEAF_COUNT);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     leaf_count_q <= '0;
		else if (cfg_wr) leaf_count_q <= pwdata[CNT_W-1:0];
	end

	// recount starts on the write edge, so it needs the value being written
	assign leaf_count_d = cfg_wr ? pwdata[CNT_W-1:0] : leaf_count_q;

	assign prdata = (paddr == REG_LEAF_COUNT) ? 32'(leaf_count_q) : 32'd0;

	lpt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg_wr (cfg_wr),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	lpt_dp #(
		.MAX_LEAVES    (MAX_LEAVES),
		.SLOT_STRIDE   (SLOT_STRIDE),
		.MAP_WORD_BITS (MAP_WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req        (req),
		.leaf_count (leaf_count_d),
		.sts        (sts),
		.rsp        (rsp),
		.rsp_valid  (done)
	);

endmodule
`default_nettype wire
